@@ rtl/core/sbf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbf_pkg
// Types, constants and bit-search helpers for the slot bitmap core.
// ----------------------------------------------------------------------------
package sbf_pkg;

  localparam int MaxSlots  = 1024;
  localparam int WordBits  = 32;
  localparam int NumWords  = MaxSlots / WordBits;
  localparam int WordAw    = $clog2(NumWords);
  localparam int BitAw     = $clog2(WordBits);
  localparam int PosW      = WordAw + BitAw;
  localparam int CntW      = PosW + 1;
  localparam int PopW      = BitAw + 1;

  localparam logic [1:0] STAT_FILLED  = 2'd0;
  localparam logic [1:0] STAT_NOFREE  = 2'd1;
  localparam logic [1:0] STAT_CLEARED = 2'd2;
  localparam logic [1:0] STAT_INVALID = 2'd3;

  localparam logic REQ_FILL  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EX,
    S_BITS,
    S_FIN
  } state_t;

  typedef logic [WordBits-1:0] word_t;

  typedef struct packed {
    logic              rd_en;
    logic [WordAw-1:0] rd_addr;
    logic              wr_en;
    logic [WordAw-1:0] wr_addr;
    word_t             wr_data;
  } mem_ctl_t;

  function automatic logic [PopW-1:0] pop32(input word_t w);
    logic [PopW-1:0] c;
    c = '0;
    for (int i = 0; i < WordBits; i++) c = c + PopW'(w[i]);
    return c;
  endfunction

  function automatic logic [BitAw-1:0] low_bit(input word_t w);
    logic [BitAw-1:0] p;
    p = '0;
    for (int i = WordBits - 1; i >= 0; i--) if (w[i]) p = BitAw'(i);
    return p;
  endfunction

  function automatic logic [BitAw-1:0] high_bit(input word_t w);
    logic [BitAw-1:0] p;
    p = '0;
    for (int i = 0; i < WordBits; i++) if (w[i]) p = BitAw'(i);
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sbf_bitmap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbf_bitmap
// Word-wide occupancy memory with a registered read; rows read as free
// until first written after reset.
// ----------------------------------------------------------------------------
module sbf_bitmap
  import sbf_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  mem_ctl_t ctl,
  output word_t    rdata
);

  word_t               mem [NumWords];
  logic [NumWords-1:0] row_vld;
  word_t               rd_q;
  logic                vld_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[ctl.wr_addr] <= ctl.wr_data;
    if (ctl.rd_en) begin
      rd_q  <= mem[ctl.rd_addr];
      vld_q <= row_vld[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (ctl.wr_en) begin
      row_vld[ctl.wr_addr] <= 1'b1;
    end
  end

  assign rdata = vld_q ? rd_q : '0;

endmodule
`default_nettype wire

@@ rtl/core/slot_bitmap_fill_and_clear_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slot_bitmap_fill_and_clear_core
// Occupancy bitmap with fill-free-slots and clear-range requests.
// ----------------------------------------------------------------------------
// One request at a time. The bitmap sits in a 32 x 32-bit memory; each word
// the request touches is read in S_RD, then modified and written back in
// S_EX. A fill that ends inside a word with more free slots than it still
// needs walks that word one bit per cycle in S_BITS. Invalid requests go
// straight from idle to S_FIN. A new request is taken while the previous
// result waits in the output register.
module slot_bitmap_fill_and_clear_core
  import sbf_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [10:0] cfg_wdata,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,  // start_pos[9:0], fill_count[20:10], end_pos[30:21]
  input  wire  [0:0]  s_axis_tuser,  // req_type[0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,  // first_slot[9:0], last_slot[19:10], freed_count[30:20]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  logic [CntW-1:0] slot_count;
  state_t state, state_next;

  logic              typ, typ_next;
  logic [PosW-1:0]   spos, spos_next;
  logic [PosW-1:0]   lim, lim_next;
  logic [WordAw-1:0] widx, widx_next;
  logic [CntW-1:0]   rem, rem_next;
  logic              found, found_next;
  logic [PosW-1:0]   first, first_next;
  logic [PosW-1:0]   last, last_next;
  logic [CntW-1:0]   freed, freed_next;
  logic [1:0]        stat, stat_next;
  word_t             wreg, wreg_next;
  word_t             freg, freg_next;
  logic [BitAw-1:0]  bidx, bidx_next;

  mem_ctl_t ctl;
  word_t    rdata;

  logic [PosW-1:0]  in_s, in_e;
  logic [CntW-1:0]  in_cnt, n_eff;
  logic [BitAw-1:0] lo_b, hi_b;
  word_t            rmask, fr;
  logic [PopW-1:0]  cnt;
  logic             word_end;

  sbf_bitmap u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= CntW'(MaxSlots);
    end else if (cfg_we) begin
      slot_count <= cfg_wdata;
    end
  end

  assign in_s   = s_axis_tdata[9:0];
  assign in_cnt = s_axis_tdata[20:10];
  assign in_e   = s_axis_tdata[30:21];
  assign n_eff  = (slot_count > CntW'(MaxSlots)) ? CntW'(MaxSlots) : slot_count;

  assign lo_b  = (widx == spos[PosW-1:BitAw]) ? spos[BitAw-1:0] : '0;
  assign hi_b  = (widx == lim[PosW-1:BitAw]) ? lim[BitAw-1:0] : '1;
  assign rmask = ('1 << lo_b) & ('1 >> (BitAw'(WordBits - 1) - hi_b));
  assign fr    = ~rdata & rmask;
  assign cnt   = (typ == REQ_FILL) ? pop32(fr) : pop32(rdata & rmask);
  assign word_end = (widx == lim[PosW-1:BitAw]);

  always_comb begin
    state_next = state;
    typ_next   = typ;
    spos_next  = spos;
    lim_next   = lim;
    widx_next  = widx;
    rem_next   = rem;
    found_next = found;
    first_next = first;
    last_next  = last;
    freed_next = freed;
    stat_next  = stat;
    wreg_next  = wreg;
    freg_next  = freg;
    bidx_next  = bidx;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          typ_next   = s_axis_tuser[0];
          spos_next  = in_s;
          lim_next   = (s_axis_tuser[0] == REQ_FILL) ? PosW'(n_eff - 1'b1) : in_e;
          widx_next  = in_s[PosW-1:BitAw];
          rem_next   = in_cnt;
          found_next = 1'b0;
          first_next = '0;
          last_next  = '0;
          freed_next = '0;
          if (s_axis_tuser[0] == REQ_FILL) begin
            if ({1'b0, in_s} < n_eff && in_cnt != '0) begin
              state_next = S_RD;
            end else begin
              stat_next  = STAT_INVALID;
              state_next = S_FIN;
            end
          end else begin
            if ({1'b0, in_s} < n_eff && {1'b0, in_e} < n_eff && in_e >= in_s) begin
              state_next = S_RD;
            end else begin
              stat_next  = STAT_INVALID;
              state_next = S_FIN;
            end
          end
        end
      end
      S_RD: state_next = S_EX;
      S_EX: begin
        if (typ == REQ_CLEAR) begin
          freed_next = freed + CntW'(cnt);
          if (word_end) begin
            stat_next  = STAT_CLEARED;
            state_next = S_FIN;
          end else begin
            widx_next  = widx + 1'b1;
            state_next = S_RD;
          end
        end else if (CntW'(cnt) > rem) begin
          wreg_next  = rdata;
          freg_next  = fr;
          bidx_next  = '0;
          state_next = S_BITS;
        end else begin
          if (cnt != '0) begin
            if (!found) first_next = {widx, low_bit(fr)};
            found_next = 1'b1;
            last_next  = {widx, high_bit(fr)};
          end
          rem_next = rem - CntW'(cnt);
          if (word_end || rem == CntW'(cnt)) begin
            stat_next  = (found || cnt != '0) ? STAT_FILLED : STAT_NOFREE;
            state_next = S_FIN;
          end else begin
            widx_next  = widx + 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_BITS: begin
        bidx_next = bidx + 1'b1;
        if (freg[bidx]) begin
          wreg_next[bidx] = 1'b1;
          if (!found) first_next = {widx, bidx};
          found_next = 1'b1;
          last_next  = {widx, bidx};
          rem_next   = rem - 1'b1;
          if (rem == CntW'(1)) begin
            stat_next  = STAT_FILLED;
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.rd_en   = (state == S_RD);
    ctl.rd_addr = widx;
    ctl.wr_addr = widx;
    ctl.wr_en   = 1'b0;
    ctl.wr_data = rdata;
    case (state)
      S_EX: begin
        if (typ == REQ_CLEAR) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_data = rdata & ~rmask;
        end else if (CntW'(cnt) <= rem) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_data = rdata | fr;
        end
      end
      S_BITS: begin
        ctl.wr_en   = freg[bidx] && rem == CntW'(1);
        ctl.wr_data = wreg | (word_t'(1) << bidx);
      end
      default: ctl.wr_en = 1'b0;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    typ   <= typ_next;
    spos  <= spos_next;
    lim   <= lim_next;
    widx  <= widx_next;
    rem   <= rem_next;
    found <= found_next;
    first <= first_next;
    last  <= last_next;
    freed <= freed_next;
    stat  <= stat_next;
    wreg  <= wreg_next;
    freg  <= freg_next;
    bidx  <= bidx_next;
    if (state == S_FIN && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tuser <= stat;
      m_axis_tdata <= {1'b0, (stat == STAT_CLEARED) ? freed : CntW'(0),
                       (stat == STAT_FILLED) ? last : PosW'(0),
                       (stat == STAT_FILLED) ? first : PosW'(0)};
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slot bitmap core: fill and clear requests are
// streamed in under random stalls and each result is compared with a local
// bitmap model kept in step with every accepted request.
// ----------------------------------------------------------------------------
module tb_top;
  import sbf_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  first_slot;
    logic [9:0]  last_slot;
    logic [10:0] freed_count;
  } slot_result_t;

  class slot_scoreboard;
    bit           occ[1024];
    int unsigned  slot_count;
    slot_result_t pending[$];
    int           errors;
    int           checked;

    function void init();
      foreach (occ[i]) occ[i] = 0;
      slot_count = 1024;
      errors = 0;
      checked = 0;
    endfunction

    function void note_request(logic req, int unsigned s, int unsigned want,
                               int unsigned e);
      slot_result_t r;
      int unsigned n, got, i;
      bit found;
      s = s & 32'h3FF;
      want = want & 32'h7FF;
      e = e & 32'h3FF;
      r = '0;
      r.status = STAT_INVALID;
      n = (slot_count > 1024) ? 1024 : slot_count;
      got = 0;
      found = 0;
      if (req == REQ_FILL) begin
        if (s < n && want != 0) begin
          for (i = s; i < n && got < want; i++) begin
            if (!occ[i]) begin
              if (!found) r.first_slot = i[9:0];
              found = 1;
              r.last_slot = i[9:0];
              got++;
            end
          end
          if (found) begin
            for (i = r.first_slot; i <= r.last_slot; i++) occ[i] = 1;
            r.status = STAT_FILLED;
          end else begin
            r.status = STAT_NOFREE;
          end
        end
      end else if (s < n && e < n && e >= s) begin
        for (i = s; i <= e; i++) begin
          r.freed_count += occ[i];
          occ[i] = 0;
        end
        r.status = STAT_CLEARED;
      end
      pending.push_back(r);
    endfunction

    task check_result(slot_result_t got);
      slot_result_t exp;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 0, got);
        return;
      end
      exp = pending.pop_front();
      if (got.status != exp.status) report_mismatch("status", exp, got);
      else if (got.first_slot != exp.first_slot) report_mismatch("first_slot", exp, got);
      else if (got.last_slot != exp.last_slot) report_mismatch("last_slot", exp, got);
      else if (got.freed_count != exp.freed_count) report_mismatch("freed_count", exp, got);
    endtask

    task report_mismatch(string what, slot_result_t exp, slot_result_t got);
      errors++;
      if (errors <= 20)
        $display("mismatch %s: exp %h got %h", what, exp, got);
    endtask
  endclass

  logic        clk, rst, cfg_we;
  logic [10:0] cfg_wdata;
  logic        s_axis_tvalid, m_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        s_axis_tready, m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  slot_bitmap_fill_and_clear_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  slot_scoreboard sb;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned cycles, fills, clears;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result({m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[19:10],
                         m_axis_tdata[30:20]});
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic req, int unsigned s, int unsigned want,
                              int unsigned e);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {1'b0, e[9:0], want[10:0], s[9:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(req, s, want, e);
    if (req == REQ_FILL) fills++;
    else clears++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_slot_count(int unsigned v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v[10:0];
    @(posedge clk);
    cfg_we <= 0;
    sb.slot_count = v[10:0];
  endtask

  task automatic random_request(int unsigned n);
    int unsigned lim, s, e, w;
    lim = (n == 0) ? 1024 : ((n > 1024) ? 1024 : n);
    s = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(lim - 1);
    e = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(lim - 1, s < lim ? s : 0);
    case ($urandom_range(3))
      0: w = $urandom_range(2047);
      1: w = $urandom_range(64, 1);
      default: w = $urandom_range(8, 1);
    endcase
    if ($urandom_range(99) < 3) w = 0;
    send_request($urandom_range(99) < 60 ? REQ_FILL : REQ_CLEAR, s, w, e);
  endtask

  initial begin
    int unsigned counts[6];
    sb = new();
    sb.init();
    counts = '{1024, 1, 2047, 37, 0, 300};
    fills = 0; clears = 0;
    rst = 1; cfg_we = 0; cfg_wdata = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0; m_axis_tready = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_request(REQ_FILL, 0, 1, 0);
    send_request(REQ_FILL, 0, 1024, 0);
    send_request(REQ_FILL, 5, 3, 0);
    send_request(REQ_CLEAR, 10, 0, 20);
    send_request(REQ_FILL, 0, 2047, 1023);
    send_request(REQ_FILL, 1023, 5, 0);
    send_request(REQ_CLEAR, 0, 0, 1023);
    send_request(REQ_FILL, 0, 0, 0);
    send_request(REQ_CLEAR, 9, 0, 8);
    send_request(REQ_FILL, 1023, 1, 1023);
    send_request(REQ_FILL, 1000, 100, 0);
    send_request(REQ_CLEAR, 1023, 0, 1023);
    send_request(REQ_FILL, 512, 1, 0);
    send_request(REQ_CLEAR, 0, 2047, 1023);

    for (int ph = 0; ph < 6; ph++) begin
      write_slot_count(counts[ph]);
      send_request(REQ_FILL, counts[ph] - 1, 1, 0);
      for (int k = 0; k < 125; k++) begin
        send_idle_pct = (k < 40) ? 13 : (k < 80) ? 79 : 0;
        recv_idle_pct = (k < 40) ? 79 : (k < 80) ? 13 : 0;
        if (k == 60) drain();
        random_request(counts[ph]);
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    $display("covered %0d fills and %0d clears over six slot counts, %0d results",
             fills, clears, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
